// ----- hw/rtl/mhpq_pkg.sv -----
// Shared types, codes and defaults of the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int EXT_W           = 64;
    localparam int OUT_COUNT_W     = 11;
    localparam int STATUS_W        = 2;
    localparam int OUT_TDATA_W     = 48;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHECK,
        S_INS_CMP,
        S_DEL_LAST,
        S_DEL_CHECK,
        S_DEL_CMP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_INS_BEGIN,
        OP_INS_READ,
        OP_INS_MOVE,
        OP_DEL_BEGIN,
        OP_DEL_TAKE,
        OP_DEL_READ,
        OP_DEL_MOVE,
        OP_WRITE_HOLE,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic is_remove;
        logic empty;
        logic full;
        logic at_root;
        logic no_child;
        logic up_more;
        logic down_more;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/mhpq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/mhpq_ctrl.sv -----
// Controller state machine that sequences inserts, removals and sifts.
`timescale 1ns / 1ps

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_op  o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.is_remove) begin
                    n_state = i_sts.empty ? S_DONE : S_DEL_LAST;
                end else begin
                    n_state = i_sts.full ? S_DONE : S_INS_CHECK;
                end
            end
            S_INS_CHECK: begin
                n_state = i_sts.at_root ? S_DONE : S_INS_CMP;
            end
            S_INS_CMP: begin
                n_state = i_sts.up_more ? S_INS_CHECK : S_DONE;
            end
            S_DEL_LAST: begin
                n_state = i_sts.empty ? S_DONE : S_DEL_CHECK;
            end
            S_DEL_CHECK: begin
                n_state = i_sts.no_child ? S_DONE : S_DEL_CMP;
            end
            S_DEL_CMP: begin
                n_state = i_sts.down_more ? S_DEL_CHECK : S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                // hold off the input while reset is applied
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) o_op = OP_LOAD;
            end
            S_DECODE: begin
                if (i_sts.is_remove) begin
                    o_op = i_sts.empty ? OP_SET_EMPTY : OP_DEL_BEGIN;
                end else begin
                    o_op = i_sts.full ? OP_SET_FULL : OP_INS_BEGIN;
                end
            end
            S_INS_CHECK: begin
                o_op = i_sts.at_root ? OP_WRITE_HOLE : OP_INS_READ;
            end
            S_INS_CMP: begin
                o_op = i_sts.up_more ? OP_INS_MOVE : OP_WRITE_HOLE;
            end
            S_DEL_LAST: begin
                // last entry was the only one: nothing left to place
                o_op = i_sts.empty ? OP_NONE : OP_DEL_TAKE;
            end
            S_DEL_CHECK: begin
                o_op = i_sts.no_child ? OP_WRITE_HOLE : OP_DEL_READ;
            end
            S_DEL_CMP: begin
                o_op = i_sts.down_more ? OP_DEL_MOVE : OP_WRITE_HOLE;
            end
            S_DONE: begin
                if (i_sts.out_free) o_op = OP_FINISH;
            end
            default: o_op = OP_NONE;
        endcase
    end

    // a word is taken only from the idle state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    // an accepted word always finishes before the next one is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("finished word did not return to idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_FINISH) |-> (r_state == S_DONE))
        else $error("result issued outside the done state");

endmodule

// ----- hw/rtl/mhpq_dp.sv -----
// Datapath: heap memory, hole position, held value, count and result register.
`timescale 1ns / 1ps

module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_op                  i_op,
    input  logic                    i_mode,
    input  logic [IN_VALUE_W-1:0]   i_value,
    input  logic                    i_out_ready,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic [IN_VALUE_W-1:0]   o_top_value,
    output logic                    o_is_empty,
    output logic [OUT_COUNT_W-1:0]  o_entry_count,
    output logic [STATUS_W-1:0]     o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_top;
    logic [AW-1:0]          r_pos;
    logic [CW-1:0]          r_cnt;
    logic                   r_mode;
    t_status                r_status;

    logic                   r_ovalid;
    logic [IN_VALUE_W-1:0]  r_otop;
    logic                   r_oempty;
    logic [OUT_COUNT_W-1:0] r_ocount;
    t_status                r_ostatus;

    logic [VALUE_WIDTH-1:0] w_rd_a;
    logic [VALUE_WIDTH-1:0] w_rd_b;
    logic [AW-1:0]          w_parent;
    logic [IW-1:0]          w_left;
    logic [IW-1:0]          w_right;
    logic                   w_left_ok;
    logic                   w_right_ok;
    logic                   w_pick_right;
    logic [VALUE_WIDTH-1:0] w_best_val;
    logic [AW-1:0]          w_best_pos;
    logic [CW-1:0]          w_last;
    logic                   w_empty;
    logic                   w_out_free;

    logic                   w_we;
    logic [AW-1:0]          w_raddr_a;
    logic [VALUE_WIDTH-1:0] w_wdata;

    logic [EXT_W-1:0]       w_in_ext;
    logic [EXT_W-1:0]       w_top_ext;
    logic [EXT_W-1:0]       w_cnt_ext;

    assign w_parent     = (r_pos - AW'(1)) >> 1;
    assign w_left       = IW'({r_pos, 1'b1});
    assign w_right      = w_left + IW'(1);
    assign w_left_ok    = w_left < IW'(r_cnt);
    assign w_right_ok   = w_right < IW'(r_cnt);
    assign w_pick_right = w_right_ok && ($signed(w_rd_a) < $signed(w_rd_b));
    assign w_best_val   = w_pick_right ? w_rd_b : w_rd_a;
    assign w_best_pos   = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_last       = r_cnt - CW'(1);
    assign w_empty      = (r_cnt == '0);
    assign w_out_free   = !r_ovalid || i_out_ready;

    assign w_in_ext  = {{(EXT_W - IN_VALUE_W){i_value[IN_VALUE_W-1]}}, i_value};
    assign w_top_ext = EXT_W'($signed(r_top));
    assign w_cnt_ext = EXT_W'(r_cnt);

    always_comb begin
        o_sts.is_remove = r_mode;
        o_sts.empty     = w_empty;
        o_sts.full      = (r_cnt == CW'(CAPACITY));
        o_sts.at_root   = (r_pos == '0);
        o_sts.no_child  = !w_left_ok;
        o_sts.up_more   = $signed(w_rd_a) < $signed(r_val);
        o_sts.down_more = $signed(r_val) < $signed(w_best_val);
        o_sts.out_free  = w_out_free;
    end

    always_comb begin
        w_we    = (i_op == OP_WRITE_HOLE) || (i_op == OP_INS_MOVE) || (i_op == OP_DEL_MOVE);
        w_wdata = r_val;
        if (i_op == OP_INS_MOVE) begin
            w_wdata = w_rd_a;
        end else if (i_op == OP_DEL_MOVE) begin
            w_wdata = w_best_val;
        end
        w_raddr_a = w_left[AW-1:0];
        if (i_op == OP_DEL_BEGIN) begin
            w_raddr_a = w_last[AW-1:0];
        end else if (i_op == OP_INS_READ) begin
            w_raddr_a = w_parent;
        end
    end

    mhpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_pos),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_right[AW-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        // mirror the root so the maximum is ready without a read
        if (w_we && r_pos == '0) begin
            r_top <= w_wdata;
        end
        unique case (i_op)
            OP_LOAD: begin
                r_val    <= w_in_ext[VALUE_WIDTH-1:0];
                r_mode   <= i_mode;
                r_status <= ST_OK;
            end
            OP_SET_FULL:  r_status <= ST_FULL;
            OP_SET_EMPTY: r_status <= ST_EMPTY;
            OP_INS_BEGIN: r_pos <= r_cnt[AW-1:0];
            OP_INS_MOVE:  r_pos <= w_parent;
            OP_DEL_BEGIN: r_pos <= '0;
            OP_DEL_TAKE:  r_val <= w_rd_a;
            OP_DEL_MOVE:  r_pos <= w_best_pos;
            OP_FINISH: begin
                r_otop    <= w_empty ? '0 : w_top_ext[IN_VALUE_W-1:0];
                r_oempty  <= w_empty;
                r_ocount  <= w_cnt_ext[OUT_COUNT_W-1:0];
                r_ostatus <= r_status;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_op == OP_INS_BEGIN) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_op == OP_DEL_BEGIN) begin
                r_cnt <= w_last;
            end
            if (i_op == OP_FINISH) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_top_value   = r_otop;
    assign o_is_empty    = r_oempty;
    assign o_entry_count = r_ocount;
    assign o_status      = r_ostatus;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IW'(r_cnt) <= IW'(CAPACITY))
        else $error("entry count above capacity");

    // every store lands inside the occupied part of the heap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (IW'(r_pos) < IW'(r_cnt)))
        else $error("heap write beyond last entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oempty == (r_ocount == '0)))
        else $error("empty flag disagrees with count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus == ST_EMPTY) |-> r_oempty)
        else $error("removal on empty reported with entries held");

endmodule

// ----- hw/rtl/max_heap_priority_queue_core.sv -----
// Top level of the max-heap priority queue: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Binary max-heap priority queue. Each input word (tuser 0) inserts the signed
// value in tdata, or (tuser 1) removes the current maximum; every input word
// yields one output word with the new maximum (zero when empty), an empty flag,
// the entry count and a status code (0 ok, 1 removal on empty ignored, 2 insert
// on full dropped). Words are handled one at a time. An insert climbs while the
// value exceeds its parent, and a removal moves the last entry to the root and
// sinks it while a child is larger; each level the entry moves costs one memory
// read and one compare-and-write on the single-write heap RAM. At CAPACITY 1024
// an insert climbs at most ten levels. A finished word waits until the output
// register is free. The result sits in an output register, so the next word is
// taken while a result waits; the heap needs no clearing after reset.
module max_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic                   s_axis_tuser,   // [0] mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] top_value, [32] is_empty,
                                                   // [43:33] entry_count, [45:44] status
);

    t_dp_op                 w_op;
    t_dp_sts                w_sts;
    logic [IN_VALUE_W-1:0]  w_top_value;
    logic                   w_is_empty;
    logic [OUT_COUNT_W-1:0] w_entry_count;
    logic [STATUS_W-1:0]    w_status;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_op       (w_op)
    );

    mhpq_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_mode        (s_axis_tuser),
        .i_value       (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_top_value   (w_top_value),
        .o_is_empty    (w_is_empty),
        .o_entry_count (w_entry_count),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {
        {(OUT_TDATA_W - IN_VALUE_W - 1 - OUT_COUNT_W - STATUS_W){1'b0}},
        w_status, w_entry_count, w_is_empty, w_top_value
    };

endmodule
